### hw/rtl/gyro_bias_calibrator_macros.svh
// ---------------------------------------------------------------------------
// gyro bias calibrator assertion macros
// shorthand for clocked implication checks, disabled while in reset
// ---------------------------------------------------------------------------
`ifndef GYRO_BIAS_CALIBRATOR_MACROS_SVH
`define GYRO_BIAS_CALIBRATOR_MACROS_SVH

// same-cycle implication
`define GBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GBC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/gbc_pkg.sv
// ---------------------------------------------------------------------------
// gbc_pkg
// shared widths, register indexes, command and status types, sample decode
// ---------------------------------------------------------------------------
package gbc_pkg;

  localparam int unsigned AXES       = 3;
  localparam int unsigned AXIS_W     = 2;
  localparam int unsigned RAW_W      = 16;
  localparam int unsigned SMP_W      = 16;
  localparam int unsigned DIFF_W     = SMP_W + 2;
  localparam int unsigned SUM_W      = 28;
  localparam int unsigned CNT_W      = 12;
  localparam int unsigned LIM_W      = 16;
  localparam int unsigned RATE_W     = 21;
  localparam int unsigned FRAC_W     = 4;
  localparam int unsigned DIVD_W     = SUM_W + FRAC_W;
  localparam int unsigned DIVC_W     = $clog2(DIVD_W);
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_STABLE_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 1'd1;

  localparam logic [LIM_W-1:0]  STABLE_LIMIT_RST = 16'd20;
  localparam logic [CNT_W-1:0]  SAMPLE_COUNT_RST = 12'd500;
  localparam logic [RAW_W-1:0]  RAW_ZERO_ALIAS   = 16'h8000;
  localparam logic [AXIS_W-1:0] AXIS_FIRST       = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_LAST        = 2'd2;

  typedef logic signed [SMP_W-1:0] smp_t;

  typedef struct packed {
    logic              load_in;
    logic              acc;
    logic              div_start;
    logic              off_wr;
    logic              cal_end;
    logic              out_load;
    logic [AXIS_W-1:0] axis;
  } gbc_cmd_t;

  typedef struct packed {
    logic end_cal;
    logic count_zero;
    logic div_busy;
    logic div_done;
  } gbc_sts_t;

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_UPDATE    = 6'b000010,
    S_CHECK     = 6'b000100,
    S_DIV_START = 6'b001000,
    S_DIV_WAIT  = 6'b010000,
    S_OUT       = 6'b100000
  } gbc_state_e;

  // two's complement word, alias pattern reads as zero, then negated
  function automatic smp_t decode_neg(input logic [RAW_W-1:0] raw);
    smp_t res;
    if (raw == RAW_ZERO_ALIAS) begin
      res = '0;
    end else begin
      res = smp_t'(~raw + 16'd1);
    end
    return res;
  endfunction

endpackage

### hw/rtl/gbc_div.sv
// ---------------------------------------------------------------------------
// gbc_div
// restoring unsigned divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module gbc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [gbc_pkg::DIVD_W-1:0] dividend_i,
  input  logic [gbc_pkg::CNT_W-1:0]  divisor_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [gbc_pkg::DIVD_W-1:0] quot_o
);
  import gbc_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  rem_q;
  logic [DIVD_W-1:0] quo_q;
  logic [CNT_W-1:0]  dsr_q;
  logic [DIVC_W-1:0] cnt_q;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_sub;
  logic              ge;

  assign rem_sh  = {rem_q, quo_q[DIVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dsr_q};
  assign rem_sub = rem_sh - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
    end else if (busy_q && (cnt_q == DIVC_W'(DIVD_W - 1))) begin
      busy_d = 1'b0;
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
      cnt_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo_q <= {quo_q[DIVD_W-2:0], ge};
      cnt_q <= cnt_q + DIVC_W'(1);
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

### hw/rtl/gbc_dp.sv
// ---------------------------------------------------------------------------
// gbc_dp
// sample decode, stillness test, sums, offset divide and rate output
// ---------------------------------------------------------------------------
module gbc_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [gbc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [gbc_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic [gbc_pkg::RAW_W-1:0]            x_raw_i,
  input  logic [gbc_pkg::RAW_W-1:0]            y_raw_i,
  input  logic [gbc_pkg::RAW_W-1:0]            z_raw_i,
  input  gbc_pkg::gbc_cmd_t                    cmd_i,
  output gbc_pkg::gbc_sts_t                    sts_o,
  output logic signed [gbc_pkg::RATE_W-1:0]    x_rate_o,
  output logic signed [gbc_pkg::RATE_W-1:0]    y_rate_o,
  output logic signed [gbc_pkg::RATE_W-1:0]    z_rate_o,
  output logic                                 calibration_done_o
);
  import gbc_pkg::*;

  logic [LIM_W-1:0]         lim_q;
  logic [CNT_W-1:0]         nsmp_q;
  logic [RAW_W-1:0]         raw      [AXES];
  smp_t                     cur_q    [AXES];
  smp_t                     prev_q   [AXES];
  logic signed [SUM_W-1:0]  sum_q    [AXES];
  logic signed [RATE_W-1:0] off_q    [AXES];
  logic signed [RATE_W-1:0] rate_q   [AXES];
  logic [CNT_W-1:0]         cnt_q;
  logic                     cal_q;
  logic                     done_q;

  logic signed [DIFF_W-1:0] diff     [AXES];
  logic signed [DIFF_W-1:0] lim_pos;
  logic signed [DIFF_W-1:0] lim_neg;
  logic                     still;
  logic                     acc_en;

  logic signed [SUM_W-1:0]  sel_sum;
  logic                     sel_neg;
  logic [SUM_W-1:0]         sel_mag;
  logic [DIVD_W-1:0]        dividend;
  logic [DIVD_W-1:0]        quot;
  logic signed [RATE_W-1:0] quot_s;
  logic signed [RATE_W-1:0] off_val;
  logic                     div_busy;
  logic                     div_done;

  assign raw[0] = x_raw_i;
  assign raw[1] = y_raw_i;
  assign raw[2] = z_raw_i;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q  <= STABLE_LIMIT_RST;
      nsmp_q <= SAMPLE_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STABLE_LIMIT: lim_q  <= cfg_data_i[LIM_W-1:0];
        REG_SAMPLE_COUNT: nsmp_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // stillness test on all axes
  assign lim_pos = $signed({2'b00, lim_q});
  assign lim_neg = -lim_pos;

  always_comb begin
    still = 1'b1;
    for (int i = 0; i < AXES; i++) begin
      diff[i] = DIFF_W'(cur_q[i]) - DIFF_W'(prev_q[i]);
      if (!((diff[i] < lim_pos) && (diff[i] > lim_neg))) begin
        still = 1'b0;
      end
    end
  end

  assign acc_en = cal_q && (cnt_q < nsmp_q);

  // offset divide, sign handled around an unsigned divider
  assign sel_sum  = sum_q[cmd_i.axis];
  assign sel_neg  = sel_sum[SUM_W-1];
  assign sel_mag  = sel_neg ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);
  assign dividend = {sel_mag, {FRAC_W{1'b0}}};
  assign quot_s   = $signed(quot[RATE_W-1:0]);
  assign off_val  = sel_neg ? -quot_s : quot_s;

  gbc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (cnt_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // calibration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      cal_q <= 1'b1;
      for (int i = 0; i < AXES; i++) begin
        sum_q[i]  <= '0;
        off_q[i]  <= '0;
        prev_q[i] <= '0;
      end
    end else begin
      if (cmd_i.acc && acc_en) begin
        if (still) begin
          cnt_q <= cnt_q + CNT_W'(1);
          for (int i = 0; i < AXES; i++) begin
            sum_q[i] <= sum_q[i] + SUM_W'(cur_q[i]);
          end
        end else begin
          cnt_q <= '0;
          for (int i = 0; i < AXES; i++) begin
            sum_q[i] <= '0;
          end
        end
      end
      if (cmd_i.off_wr) begin
        for (int i = 0; i < AXES; i++) begin
          if (cmd_i.axis == AXIS_W'(i)) begin
            off_q[i] <= off_val;
          end
        end
      end
      if (cmd_i.cal_end) begin
        cal_q <= 1'b0;
      end
      if (cmd_i.out_load) begin
        for (int i = 0; i < AXES; i++) begin
          prev_q[i] <= cur_q[i];
        end
      end
    end
  end

  // sample and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      for (int i = 0; i < AXES; i++) begin
        cur_q[i] <= decode_neg(raw[i]);
      end
    end
    if (cmd_i.out_load) begin
      done_q <= !cal_q;
      for (int i = 0; i < AXES; i++) begin
        rate_q[i] <= $signed({cur_q[i][SMP_W-1], cur_q[i], {FRAC_W{1'b0}}}) - off_q[i];
      end
    end
  end

  assign sts_o.end_cal    = cal_q && (cnt_q >= nsmp_q);
  assign sts_o.count_zero = (cnt_q == '0);
  assign sts_o.div_busy   = div_busy;
  assign sts_o.div_done   = div_done;

  assign x_rate_o           = rate_q[0];
  assign y_rate_o           = rate_q[1];
  assign z_rate_o           = rate_q[2];
  assign calibration_done_o = done_q;

endmodule

### hw/rtl/gbc_ctrl.sv
// ---------------------------------------------------------------------------
// gbc_ctrl
// item sequencer: accept, accumulate, offset divide per axis, result beat
// ---------------------------------------------------------------------------
module gbc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  gbc_pkg::gbc_sts_t sts_i,
  output gbc_pkg::gbc_cmd_t cmd_o
);
  import gbc_pkg::*;

  gbc_state_e        state_q, state_d;
  logic [AXIS_W-1:0] axis_q, axis_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;
  gbc_cmd_t          cmd;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d  = state_q;
    axis_d   = axis_q;
    cmd      = '0;
    cmd.axis = axis_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load_in = 1'b1;
          state_d     = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.acc = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.end_cal && !sts_i.count_zero) begin
          axis_d  = AXIS_FIRST;
          state_d = S_DIV_START;
        end else begin
          cmd.cal_end = sts_i.end_cal;
          state_d     = S_OUT;
        end
      end
      S_DIV_START: begin
        cmd.div_start = 1'b1;
        state_d       = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts_i.div_done) begin
          cmd.off_wr = 1'b1;
          if (axis_q == AXIS_LAST) begin
            cmd.cal_end = 1'b1;
            state_d     = S_OUT;
          end else begin
            axis_d  = axis_q + AXIS_W'(1);
            state_d = S_DIV_START;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= AXIS_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

### hw/rtl/gyro_bias_calibrator.sv
// ---------------------------------------------------------------------------
// gyro_bias_calibrator: three-axis gyro zero-rate offset removal, one beat per item
// each item runs through update, check and output states; input is stalled until idle
// the item ending calibration runs the bit-serial offset divider per axis if count is nonzero
// reset: limit 20, count 500, sums, offsets and previous sample cleared, calibrating
// ---------------------------------------------------------------------------
module gyro_bias_calibrator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [gbc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [gbc_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [gbc_pkg::RAW_W-1:0]            x_raw_i,
  input  logic [gbc_pkg::RAW_W-1:0]            y_raw_i,
  input  logic [gbc_pkg::RAW_W-1:0]            z_raw_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [gbc_pkg::RATE_W-1:0]    x_rate_o,
  output logic signed [gbc_pkg::RATE_W-1:0]    y_rate_o,
  output logic signed [gbc_pkg::RATE_W-1:0]    z_rate_o,
  output logic                                 calibration_done_o
);
  import gbc_pkg::*;

  gbc_cmd_t cmd;
  gbc_sts_t sts;
  logic     div_ok;
  logic     res_free;
  logic     in_take;

  gbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gbc_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .x_raw_i            (x_raw_i),
    .y_raw_i            (y_raw_i),
    .z_raw_i            (z_raw_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .x_rate_o           (x_rate_o),
    .y_rate_o           (y_rate_o),
    .z_rate_o           (z_rate_o),
    .calibration_done_o (calibration_done_o)
  );

  assign div_ok   = sts.end_cal && !sts.count_zero && !sts.div_busy;
  assign res_free = !out_valid_o || !out_stall_i;
  assign in_take  = in_valid_i && !in_stall_o;

`include "gyro_bias_calibrator_macros.svh"

  `GBC_ASSERT_IMP(a_div_at_end, cmd.div_start, div_ok, "divide outside calibration end")
  `GBC_ASSERT_IMP(a_off_after_div, cmd.off_wr, sts.div_done, "offset written before divide done")
  `GBC_ASSERT_IMP(a_no_overwrite, cmd.out_load, res_free, "pending result beat overwritten")
  `GBC_ASSERT_NXT(a_one_item, in_take, in_stall_o, "second item taken while one is in work")

endmodule

### test/tb_gyro_bias_calibrator.sv
// ---------------------------------------------------------------------------
// tb_gyro_bias_calibrator
// drives gyro samples through the calibrator with random idling on both
// sides, predicts every rate beat from its own copy of the calibration
// state and compares each output beat field by field in arrival order
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_gyro_bias_calibrator;

  import gbc_pkg::*;

  localparam int QUIET_LIMIT = 4000;

  typedef logic signed [RATE_W-1:0] rate_t;

  typedef struct {
    rate_t x;
    rate_t y;
    rate_t z;
    logic  done;
  } rate_beat_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [RAW_W-1:0]      x_raw_i     = '0;
  logic [RAW_W-1:0]      y_raw_i     = '0;
  logic [RAW_W-1:0]      z_raw_i     = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  rate_t                 x_rate_o;
  rate_t                 y_rate_o;
  rate_t                 z_rate_o;
  logic                  calibration_done_o;

  // calibration state mirror
  logic [LIM_W-1:0] still_lim  = STABLE_LIMIT_RST;
  logic [CNT_W-1:0] avg_len    = SAMPLE_COUNT_RST;
  int               prev_smp [AXES];
  longint           smp_sums [AXES];
  logic [CNT_W-1:0] still_cnt  = '0;
  bit               cal_active = 1'b1;
  int               offsets  [AXES];

  rate_beat_t pending_rates [$];
  int         busy_pct    = 29;
  int         err_cnt     = 0;
  int         quiet_cycles = 0;

  gyro_bias_calibrator uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .x_raw_i            (x_raw_i),
    .y_raw_i            (y_raw_i),
    .z_raw_i            (z_raw_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .x_rate_o           (x_rate_o),
    .y_rate_o           (y_rate_o),
    .z_rate_o           (z_rate_o),
    .calibration_done_o (calibration_done_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // two's complement word with the alias pattern as zero, negated
  function automatic int neg_sample(input logic [RAW_W-1:0] raw);
    if (raw == RAW_ZERO_ALIAS) begin
      return 0;
    end
    return -int'($signed(raw));
  endfunction

  function automatic logic [RAW_W-1:0] rand_word();
    logic [RAW_W-1:0] corner [6] = '{16'h0000, 16'h0001, 16'h7FFF,
                                     16'h8000, 16'h8001, 16'hFFFF};
    if ($urandom_range(0, 9) == 0) begin
      return corner[$urandom_range(0, 5)];
    end
    return RAW_W'($urandom);
  endfunction

  // one accepted sample: stillness test, accumulation, offset, rates
  task automatic track_calibration(input logic [RAW_W-1:0] xr, yr, zr);
    int         cur [AXES];
    int         d;
    int         lim;
    bit         still;
    rate_beat_t beat;
    cur[0] = neg_sample(xr);
    cur[1] = neg_sample(yr);
    cur[2] = neg_sample(zr);
    if (cal_active && still_cnt < avg_len) begin
      still = 1'b1;
      lim   = int'(still_lim);
      for (int i = 0; i < AXES; i++) begin
        d = cur[i] - prev_smp[i];
        if (!(d < lim && d > -lim)) begin
          still = 1'b0;
        end
      end
      for (int i = 0; i < AXES; i++) begin
        smp_sums[i] = still ? smp_sums[i] + cur[i] : 0;
      end
      still_cnt = still ? still_cnt + 1'b1 : '0;
    end
    if (cal_active && still_cnt >= avg_len) begin
      for (int i = 0; i < AXES; i++) begin
        offsets[i] = (still_cnt == 0) ? 0 :
                     int'((smp_sums[i] * 16) / longint'(still_cnt));
      end
      cal_active = 1'b0;
    end
    beat.x    = rate_t'(longint'(cur[0]) * 16 - offsets[0]);
    beat.y    = rate_t'(longint'(cur[1]) * 16 - offsets[1]);
    beat.z    = rate_t'(longint'(cur[2]) * 16 - offsets[2]);
    beat.done = !cal_active;
    for (int i = 0; i < AXES; i++) begin
      prev_smp[i] = cur[i];
    end
    pending_rates.push_back(beat);
  endtask

  task automatic push_sample(input logic [RAW_W-1:0] xr, yr, zr);
    while (busy_pct != 0 && $urandom_range(0, 99) < busy_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    x_raw_i    <= xr;
    y_raw_i    <= yr;
    z_raw_i    <= zr;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    track_calibration(xr, yr, zr);
  endtask

  // drain outstanding beats so registers change only while idle
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_rates.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == REG_STABLE_LIMIT) begin
      still_lim = data[LIM_W-1:0];
    end else if (idx == REG_SAMPLE_COUNT) begin
      avg_len = data[CNT_W-1:0];
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic report_field(input string label, input rate_t want, input rate_t got);
    if (got !== want) begin
      $display("%0t %s mismatch expected %0d actual %0d", $time, label, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : rate_check
    rate_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rates.size() == 0) begin
        $display("%0t unexpected beat expected none actual x %0d y %0d z %0d done %0b",
                 $time, x_rate_o, y_rate_o, z_rate_o, calibration_done_o);
        err_cnt++;
      end else begin
        want = pending_rates.pop_front();
        report_field("x_rate", want.x, x_rate_o);
        report_field("y_rate", want.y, y_rate_o);
        report_field("z_rate", want.z, z_rate_o);
        report_field("calibration_done", rate_t'(want.done), rate_t'(calibration_done_o));
      end
    end
    out_stall_i <= busy_pct != 0 && $urandom_range(0, 99) < busy_pct;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o)
        || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t watchdog expired with %0d beats outstanding", $time,
               pending_rates.size());
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // reset settings: word extremes, alias pattern, limit edge at 20
  task automatic test_raw_extremes();
    push_sample(16'h0000, 16'h7FFF, 16'h8000);
    push_sample(16'h8001, 16'hFFFF, 16'h0001);
    push_sample(16'h7FFF, 16'h8000, 16'h0000);
    push_sample(16'hFFFF, 16'h0001, 16'h8001);
    push_sample(16'h8000, 16'h8000, 16'h8000);
    push_sample(16'h8000, 16'h8000, 16'h8000);
    push_sample(16'h0013, 16'hFFED, 16'h8000);
    push_sample(16'h0000, 16'h0000, 16'h0000);
    push_sample(16'h0014, 16'h0000, 16'h0000);
  endtask

  // zero limit: nothing is still
  task automatic test_limit_zero();
    settle();
    write_reg(REG_STABLE_LIMIT, 16'd0);
    repeat (3) push_sample(16'h0000, 16'h0000, 16'h0000);
  endtask

  // limit of one: only unchanged samples count
  task automatic test_limit_one();
    settle();
    write_reg(REG_STABLE_LIMIT, 16'd1);
    repeat (3) push_sample(16'h1234, 16'hABCD, 16'h8000);
    push_sample(16'h1235, 16'hABCD, 16'h8000);
    push_sample(16'h1235, 16'hABCD, 16'h8000);
    push_sample(16'h1235, 16'hABCD, 16'h0001);
  endtask

  // random walks with steps up to the limit, broken by noise, at the longest average
  task automatic test_still_runs();
    int               lim;
    int               stride;
    int               walk [AXES];
    logic [RAW_W-1:0] w [AXES];
    settle();
    write_reg(REG_SAMPLE_COUNT, CFG_DATA_W'(4095));
    for (int phase = 0; phase < 6; phase++) begin
      lim = (phase == 0) ? 2 : (phase == 5) ? 65535 : $urandom_range(3, 500);
      stride = (lim > 40000) ? 40000 : lim;
      settle();
      write_reg(REG_STABLE_LIMIT, CFG_DATA_W'(lim));
      for (int i = 0; i < AXES; i++) begin
        walk[i] = $urandom_range(0, 65535);
      end
      repeat (100) begin
        if ($urandom_range(0, 99) < 12) begin
          if ($urandom_range(0, 1) == 0) begin
            walk[$urandom_range(0, AXES - 1)] = int'(rand_word());
          end else begin
            for (int i = 0; i < AXES; i++) begin
              walk[i] = int'(rand_word());
            end
          end
        end else begin
          for (int i = 0; i < AXES; i++) begin
            walk[i] = walk[i] + $urandom_range(0, 2 * stride) - stride;
          end
        end
        for (int i = 0; i < AXES; i++) begin
          w[i] = RAW_W'(walk[i]);
        end
        push_sample(w[0], w[1], w[2]);
      end
    end
  endtask

  // count lowered below the run already gathered: ends without adding
  task automatic test_early_end();
    settle();
    write_reg(REG_STABLE_LIMIT, 16'hFFFF);
    repeat (40) push_sample(rand_word(), rand_word(), rand_word());
    settle();
    write_reg(REG_SAMPLE_COUNT, CFG_DATA_W'(1));
    repeat (5) push_sample(rand_word(), rand_word(), rand_word());
  endtask

  // offsets frozen; register writes no longer matter
  task automatic test_post_calibration();
    settle();
    write_reg(REG_STABLE_LIMIT, 16'd0);
    write_reg(REG_SAMPLE_COUNT, CFG_DATA_W'(0));
    repeat (250) push_sample(rand_word(), rand_word(), rand_word());
    settle();
    write_reg(REG_STABLE_LIMIT, 16'hFFFF);
    write_reg(REG_SAMPLE_COUNT, CFG_DATA_W'(4095));
    busy_pct = 0;
    repeat (250) push_sample(rand_word(), rand_word(), rand_word());
    busy_pct = 29;
    repeat (50) push_sample(rand_word(), rand_word(), rand_word());
  endtask

  initial begin
    for (int i = 0; i < AXES; i++) begin
      prev_smp[i] = 0;
      smp_sums[i] = 0;
      offsets[i]  = 0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_raw_extremes();
    test_limit_zero();
    test_limit_one();
    test_still_runs();
    test_early_end();
    test_post_calibration();
    settle();
    repeat (12) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
